>>> rtl/srcie_pkg.sv
// ----------------------------------------------------------------------------
// srcie_pkg
// Opcodes, branch conditions, status and request codes for the SRC execute
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package srcie_pkg;

	typedef logic [1:0]  status_t;
	typedef logic [1:0]  req_t;
	typedef logic [4:0]  opcode_t;
	typedef logic [4:0]  reg_idx_t;
	typedef logic [31:0] word_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_STOP    = 2'd2;
	localparam status_t ST_ORDER   = 2'd3;

	localparam req_t REQ_NONE  = 2'd0;
	localparam req_t REQ_READ  = 2'd1;
	localparam req_t REQ_WRITE = 2'd2;

	localparam opcode_t OP_NOP  = 5'd0;
	localparam opcode_t OP_LD   = 5'd1;
	localparam opcode_t OP_LDR  = 5'd2;
	localparam opcode_t OP_ST   = 5'd3;
	localparam opcode_t OP_STR  = 5'd4;
	localparam opcode_t OP_LA   = 5'd5;
	localparam opcode_t OP_LAR  = 5'd6;
	localparam opcode_t OP_BAD7 = 5'd7;
	localparam opcode_t OP_BR   = 5'd8;
	localparam opcode_t OP_BRL  = 5'd9;
	localparam opcode_t OP_EEN  = 5'd10;
	localparam opcode_t OP_EDI  = 5'd11;
	localparam opcode_t OP_ADD  = 5'd12;
	localparam opcode_t OP_ADDI = 5'd13;
	localparam opcode_t OP_SUB  = 5'd14;
	localparam opcode_t OP_NEG  = 5'd15;
	localparam opcode_t OP_SVI  = 5'd16;
	localparam opcode_t OP_RI   = 5'd17;
	localparam opcode_t OP_BAD18 = 5'd18;
	localparam opcode_t OP_BAD19 = 5'd19;
	localparam opcode_t OP_AND  = 5'd20;
	localparam opcode_t OP_ANDI = 5'd21;
	localparam opcode_t OP_OR   = 5'd22;
	localparam opcode_t OP_ORI  = 5'd23;
	localparam opcode_t OP_NOT  = 5'd24;
	localparam opcode_t OP_BAD25 = 5'd25;
	localparam opcode_t OP_SHR  = 5'd26;
	localparam opcode_t OP_SHRA = 5'd27;
	localparam opcode_t OP_SHL  = 5'd28;
	localparam opcode_t OP_SHC  = 5'd29;
	localparam opcode_t OP_RFI  = 5'd30;
	localparam opcode_t OP_STOP = 5'd31;

	localparam logic [2:0] CND_NEVER  = 3'd0;
	localparam logic [2:0] CND_ALWAYS = 3'd1;
	localparam logic [2:0] CND_ZERO   = 3'd2;
	localparam logic [2:0] CND_NZERO  = 3'd3;
	localparam logic [2:0] CND_PLUS   = 3'd4;
	localparam logic [2:0] CND_MINUS  = 3'd5;

	localparam word_t PC_STEP = 32'd4;

	function automatic word_t sext_c1(input word_t w);
		return {{10{w[21]}}, w[21:0]};
	endfunction

	function automatic word_t sext_c2(input word_t w);
		return {{15{w[16]}}, w[16:0]};
	endfunction

	function automatic logic cond_met(input logic [2:0] cnd, input word_t v);
		logic r;
		r = 1'b0;
		case (cnd)
			CND_ALWAYS: r = 1'b1;
			CND_ZERO:   r = (v == '0);
			CND_NZERO:  r = (v != '0);
			CND_PLUS:   r = ~v[31];
			CND_MINUS:  r = v[31];
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/src_risc_instruction_execute.sv
// ----------------------------------------------------------------------------
// src_risc_instruction_execute
// SRC execute unit: register file in a synchronous RAM, read at accept,
// modified in one stage and written back, with a bypass for back-to-back use.
// ----------------------------------------------------------------------------
// An accepted beat is registered into the execute stage; when that stage fires,
//   its result is registered into the output register.
// Throughput: one beat per cycle unless out_ready stalls; set by the single
//   read-modify-write stage around the register RAM (2 read, 1 write ports).
// Reset: arst_n clears control state; register file reads as zero through
//   per-entry valid bits, next-PC is zero until start_address is written.
`default_nettype none

module src_risc_instruction_execute (
	input  wire                 clk,
	input  wire                 arst_n,
	// configuration: start_address, also loads next-PC
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [31:0]         cfg_data,
	// input channel
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 kind,
	input  wire  [31:0]         instruction_word,
	input  wire  [31:0]         read_data,
	// result channel
	output logic                out_valid,
	input  wire                 out_ready,
	output srcie_pkg::status_t  status,
	output srcie_pkg::req_t     mem_request,
	output logic [31:0]         mem_address,
	output logic [31:0]         mem_write_data,
	output logic [31:0]         next_fetch_pc
);
	import srcie_pkg::*;

	// register file RAM and its per-entry valid bits
	word_t       rf_mem [32];
	logic [31:0] rf_vld_q;

	// architectural control state
	word_t       next_pc_q;
	logic        load_pending_q;
	reg_idx_t    load_target_q;

	// execute stage
	logic        v_s1;
	logic        kind_s1;
	word_t       iw_s1;
	word_t       rdat_s1;
	word_t       porta_s1;     // R[rb]
	word_t       portb_s1;     // R[ra] for stores, R[rc] otherwise
	logic        va_s1;
	logic        vb_s1;

	// last write-back, bypassed to the following beat
	logic        wb_en_q;
	reg_idx_t    wb_addr_q;
	word_t       wb_data_q;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	req_t        req_q;
	word_t       addr_q;
	word_t       wdata_q;
	word_t       npc_q;

	logic        accept;
	logic        fire;
	opcode_t     in_op;
	reg_idx_t    in_pb_addr;

	assign cfg_ready = 1'b1;
	assign fire      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !v_s1 || fire;
	assign accept    = in_valid && in_ready;

	// stores read ra on port B; everything else needs rc there
	assign in_op      = instruction_word[31:27];
	assign in_pb_addr = (in_op == OP_ST || in_op == OP_STR) ?
	                    instruction_word[26:22] : instruction_word[16:12];

	// ---------------- execute stage: decode, bypass, compute ----------------
	opcode_t  op;
	reg_idx_t ra_f, rb_f, rc_f, pb_f;
	word_t    rbv, pbv, c2, disp, rel, pc_inc;
	logic [4:0] amt;

	status_t  x_status;
	req_t     x_req;
	word_t    x_addr, x_wdata, x_npc;
	logic     x_lp;
	reg_idx_t x_lt;
	logic     x_we;
	reg_idx_t x_wa;
	word_t    x_wd;

	always_comb begin
		op   = iw_s1[31:27];
		ra_f = iw_s1[26:22];
		rb_f = iw_s1[21:17];
		rc_f = iw_s1[16:12];
		pb_f = (op == OP_ST || op == OP_STR) ? ra_f : rc_f;

		// RAM returns pre-write data when the previous beat wrote the same entry
		if (wb_en_q && wb_addr_q == rb_f) begin
			rbv = wb_data_q;
		end else begin
			rbv = va_s1 ? porta_s1 : '0;
		end
		if (wb_en_q && wb_addr_q == pb_f) begin
			pbv = wb_data_q;
		end else begin
			pbv = vb_s1 ? portb_s1 : '0;
		end

		c2     = sext_c2(iw_s1);
		disp   = (rb_f == '0) ? c2 : c2 + rbv;
		pc_inc = next_pc_q + PC_STEP;
		rel    = sext_c1(iw_s1) + pc_inc;
		amt    = (iw_s1[4:0] != '0) ? iw_s1[4:0] : pbv[4:0];

		x_status = ST_OK;
		x_req    = REQ_NONE;
		x_addr   = '0;
		x_wdata  = '0;
		x_npc    = next_pc_q;
		x_lp     = load_pending_q;
		x_lt     = load_target_q;
		x_we     = 1'b0;
		x_wa     = ra_f;
		x_wd     = '0;

		if (kind_s1) begin
			// returning read data
			if (!load_pending_q) begin
				x_status = ST_ORDER;
			end else begin
				x_we = 1'b1;
				x_wa = load_target_q;
				x_wd = rdat_s1;
				x_lp = 1'b0;
			end
		end else if (load_pending_q) begin
			x_status = ST_ORDER;
		end else if (op inside {OP_BAD7, OP_BAD18, OP_BAD19, OP_BAD25}) begin
			// bad opcode: PC holds
			x_status = ST_INVALID;
		end else begin
			x_npc = pc_inc;
			unique case (op)
				OP_LD: begin
					x_req = REQ_READ; x_addr = disp; x_lp = 1'b1; x_lt = ra_f;
				end
				OP_LDR: begin
					x_req = REQ_READ; x_addr = rel; x_lp = 1'b1; x_lt = ra_f;
				end
				OP_ST: begin
					x_req = REQ_WRITE; x_addr = disp; x_wdata = pbv;
				end
				OP_STR: begin
					x_req = REQ_WRITE; x_addr = rel; x_wdata = pbv;
				end
				OP_LA:   begin x_we = 1'b1; x_wd = disp; end
				OP_LAR:  begin x_we = 1'b1; x_wd = rel; end
				OP_BR: begin
					if (cond_met(iw_s1[2:0], pbv)) x_npc = rbv;
				end
				OP_BRL: begin
					// link value and branch operands are pre-write
					x_we = 1'b1;
					x_wd = pc_inc;
					if (cond_met(iw_s1[2:0], pbv)) x_npc = rbv;
				end
				OP_ADD:  begin x_we = 1'b1; x_wd = rbv + pbv; end
				OP_ADDI: begin x_we = 1'b1; x_wd = rbv + c2; end
				OP_SUB:  begin x_we = 1'b1; x_wd = rbv - pbv; end
				OP_NEG:  begin x_we = 1'b1; x_wd = '0 - pbv; end
				OP_AND:  begin x_we = 1'b1; x_wd = rbv & pbv; end
				OP_ANDI: begin x_we = 1'b1; x_wd = rbv & c2; end
				OP_OR:   begin x_we = 1'b1; x_wd = rbv | pbv; end
				OP_ORI:  begin x_we = 1'b1; x_wd = rbv | c2; end
				OP_NOT:  begin x_we = 1'b1; x_wd = ~pbv; end
				OP_SHR:  begin x_we = 1'b1; x_wd = rbv >> amt; end
				OP_SHRA: begin x_we = 1'b1; x_wd = word_t'($signed(rbv) >>> amt); end
				OP_SHL:  begin x_we = 1'b1; x_wd = rbv << amt; end
				OP_STOP: begin x_status = ST_STOP; end
				// nop, een, edi, svi, ri, shc, rfi: PC advance only
				default: begin end
			endcase
		end
	end

	// ---------------- register RAM: two reads at accept, one write ----------
	always_ff @(posedge clk) begin
		if (fire && x_we) begin
			rf_mem[x_wa] <= x_wd;
		end
		if (accept) begin
			porta_s1 <= rf_mem[instruction_word[21:17]];
			portb_s1 <= rf_mem[in_pb_addr];
			va_s1    <= rf_vld_q[instruction_word[21:17]];
			vb_s1    <= rf_vld_q[in_pb_addr];
			kind_s1  <= kind;
			iw_s1    <= instruction_word;
			rdat_s1  <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (fire && x_we) begin
			rf_vld_q[x_wa] <= 1'b1;
		end
	end

	// ---------------- control state and bypass register ---------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			next_pc_q      <= '0;
			load_pending_q <= 1'b0;
			load_target_q  <= '0;
			wb_en_q        <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				next_pc_q <= cfg_data;
			end else if (fire) begin
				next_pc_q <= x_npc;
			end
			if (fire) begin
				load_pending_q <= x_lp;
				load_target_q  <= x_lt;
				wb_en_q        <= x_we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			wb_addr_q <= x_wa;
			wb_data_q <= x_wd;
		end
	end

	// ---------------- result register ---------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= x_status;
			req_q    <= x_req;
			addr_q   <= x_addr;
			wdata_q  <= x_wdata;
			npc_q    <= x_npc;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign mem_request    = req_q;
	assign mem_address    = addr_q;
	assign mem_write_data = wdata_q;
	assign next_fetch_pc  = npc_q;

endmodule

`default_nettype wire

>>> tb/srcie_exec_checker.sv
// ----------------------------------------------------------------------------
// srcie_exec_checker
// Watches the config, instruction and result channels of the SRC execute
// block. Keeps its own register file, next-PC and load state, works out the
// result of every accepted beat and compares it with the returned beat.
// ----------------------------------------------------------------------------
module srcie_exec_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                kind,
	input  logic [31:0]         instruction_word,
	input  logic [31:0]         read_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  srcie_pkg::status_t  status,
	input  srcie_pkg::req_t     mem_request,
	input  logic [31:0]         mem_address,
	input  logic [31:0]         mem_write_data,
	input  logic [31:0]         next_fetch_pc,
	output int                  errors,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import srcie_pkg::*;

	typedef struct packed {
		status_t status;
		req_t    req;
		word_t   addr;
		word_t   wdata;
		word_t   npc;
	} retire_t;

	word_t    regs [32];
	word_t    nxt_pc;
	logic     ld_pending;
	reg_idx_t ld_target;
	retire_t  retire_q [$];

	function automatic logic branch_taken(input logic [2:0] cnd, input word_t v);
		case (cnd)
			CND_ALWAYS: return 1'b1;
			CND_ZERO:   return v == '0;
			CND_NZERO:  return v != '0;
			CND_PLUS:   return !v[31];
			CND_MINUS:  return v[31];
			default:    return 1'b0;
		endcase
	endfunction

	// Executes one beat against the shadow state, returns its retire record.
	function automatic retire_t execute_beat(input logic k, input word_t w, input word_t rd);
		retire_t  r;
		opcode_t  op;
		reg_idx_t ra, rb, rc;
		word_t    rbv, rcv, c2, disp, rel, link;
		logic [4:0] amt;
		r = '0;
		op = w[31:27];
		if (k) begin
			if (!ld_pending) begin
				r.status = ST_ORDER;
			end else begin
				regs[ld_target] = rd;
				ld_pending = 1'b0;
			end
			r.npc = nxt_pc;
			return r;
		end
		if (ld_pending) begin
			r.status = ST_ORDER;
			r.npc = nxt_pc;
			return r;
		end
		if (op inside {OP_BAD7, OP_BAD18, OP_BAD19, OP_BAD25}) begin
			r.status = ST_INVALID;
			r.npc = nxt_pc;
			return r;
		end
		ra = w[26:22];
		rb = w[21:17];
		rc = w[16:12];
		rbv = regs[rb];
		rcv = regs[rc];
		c2 = {{15{w[16]}}, w[16:0]};
		disp = (rb == '0) ? c2 : c2 + rbv;
		amt = (w[4:0] != '0) ? w[4:0] : rcv[4:0];
		nxt_pc = nxt_pc + PC_STEP;
		rel = {{10{w[21]}}, w[21:0]} + nxt_pc;
		case (op)
			OP_LD, OP_LDR: begin
				r.req = REQ_READ;
				r.addr = (op == OP_LD) ? disp : rel;
				ld_pending = 1'b1;
				ld_target = ra;
			end
			OP_ST, OP_STR: begin
				r.req = REQ_WRITE;
				r.addr = (op == OP_ST) ? disp : rel;
				r.wdata = regs[ra];
			end
			OP_LA:   regs[ra] = disp;
			OP_LAR:  regs[ra] = rel;
			OP_BR:   if (branch_taken(w[2:0], rcv)) nxt_pc = rbv;
			OP_BRL: begin
				// condition and target read before the link lands
				link = nxt_pc;
				if (branch_taken(w[2:0], rcv)) nxt_pc = rbv;
				regs[ra] = link;
			end
			OP_ADD:  regs[ra] = rbv + rcv;
			OP_ADDI: regs[ra] = rbv + c2;
			OP_SUB:  regs[ra] = rbv - rcv;
			OP_NEG:  regs[ra] = -rcv;
			OP_AND:  regs[ra] = rbv & rcv;
			OP_ANDI: regs[ra] = rbv & c2;
			OP_OR:   regs[ra] = rbv | rcv;
			OP_ORI:  regs[ra] = rbv | c2;
			OP_NOT:  regs[ra] = ~rcv;
			OP_SHR:  regs[ra] = rbv >> amt;
			OP_SHRA: regs[ra] = $signed(rbv) >>> amt;
			OP_SHL:  regs[ra] = rbv << amt;
			OP_STOP: r.status = ST_STOP;
			default: ;
		endcase
		r.npc = nxt_pc;
		return r;
	endfunction

	task automatic check_field(input string tag, input word_t exp_v, input word_t act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, tag, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		retire_t e;
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			nxt_pc = '0;
			ld_pending = 1'b0;
			ld_target = '0;
			retire_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				nxt_pc = cfg_data;
			end
			// results first: a beat accepted this edge cannot retire this edge
			if (out_valid && out_ready) begin
				if (retire_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, status %h pc %h",
						$time, status, next_fetch_pc);
				end else begin
					e = retire_q.pop_front();
					check_field("status", word_t'(e.status), word_t'(status));
					check_field("mem_request", word_t'(e.req), word_t'(mem_request));
					check_field("mem_address", e.addr, mem_address);
					check_field("mem_write_data", e.wdata, mem_write_data);
					check_field("next_fetch_pc", e.npc, next_fetch_pc);
				end
			end
			if (in_valid && in_ready)
				retire_q.push_back(execute_beat(kind, instruction_word, read_data));
		end
		outstanding = retire_q.size();
	end

	initial begin
		errors = 0;
		outstanding = 0;
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the SRC execute block. A directed opening covers
// immediates at their limits, loads, stores, shifts, branches, bad opcodes,
// stop and out-of-order beats; random phases under several start addresses
// follow. Checking is done by srcie_exec_checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srcie_pkg::*;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int PHASE_BEATS  = 385;
	localparam int PHASES       = 5;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [31:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [31:0] instruction_word;
	logic [31:0] read_data;
	logic       out_valid;
	logic       out_ready;
	status_t    status;
	req_t       mem_request;
	logic [31:0] mem_address;
	logic [31:0] mem_write_data;
	logic [31:0] next_fetch_pc;

	int   err_count;
	int   outstanding;
	int   cycle_count;

	// idling switches, flipped per phase by the main sequence
	logic tx_idle_en;
	logic rx_idle_en;

	// load open on the block side as far as the sender can tell; shapes the
	// random stream so most loads are followed by their read-data beat
	logic ld_open;

	src_risc_instruction_execute DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.instruction_word (instruction_word),
		.read_data        (read_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.mem_request      (mem_request),
		.mem_address      (mem_address),
		.mem_write_data   (mem_write_data),
		.next_fetch_pc    (next_fetch_pc)
	);

	srcie_exec_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.instruction_word (instruction_word),
		.read_data        (read_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.mem_request      (mem_request),
		.mem_address      (mem_address),
		.mem_write_data   (mem_write_data),
		.next_fetch_pc    (next_fetch_pc),
		.errors           (err_count),
		.outstanding      (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: a hung handshake ends here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	// Result side: ready drops for random stretches while enabled.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Instruction encoders for the three SRC formats.
	function automatic word_t enc_c2(input opcode_t op, input reg_idx_t ra,
			input reg_idx_t rb, input logic [16:0] c2);
		return {op, ra, rb, c2};
	endfunction

	function automatic word_t enc_c1(input opcode_t op, input reg_idx_t ra,
			input logic [21:0] c1);
		return {op, ra, c1};
	endfunction

	function automatic word_t enc_rrr(input opcode_t op, input reg_idx_t ra,
			input reg_idx_t rb, input reg_idx_t rc, input logic [11:0] low);
		return {op, ra, rb, rc, low};
	endfunction

	// Random instruction: loads and branches weighted up, shift-by-register,
	// absolute addressing and c2 at its limits mixed in.
	function automatic word_t rand_instr();
		word_t   w;
		opcode_t op;
		w = $urandom();
		case ($urandom_range(0, 9))
			0, 1:    op = $urandom_range(0, 1) ? OP_LD : OP_LDR;
			2:       op = $urandom_range(0, 1) ? OP_BR : OP_BRL;
			default: op = opcode_t'($urandom_range(0, 31));
		endcase
		w[31:27] = op;
		if ($urandom_range(0, 3) == 0)
			w[4:0] = '0;
		if ($urandom_range(0, 5) == 0)
			w[21:17] = '0;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: w[16:0] = 17'h0FFFF;
				1: w[16:0] = 17'h10000;
				2: w[16:0] = 17'h1FFFF;
				default: w[16:0] = 17'h00000;
			endcase
		end
		return w;
	endfunction

	function automatic word_t rand_data();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// One beat on the input channel, then maybe a random gap with valid low.
	task automatic issue(input logic k, input word_t w, input word_t rd);
		@(negedge clk);
		kind <= k;
		instruction_word <= w;
		read_data <= rd;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (k)
			ld_open = 1'b0;
		else if (!ld_open && (w[31:27] == OP_LD || w[31:27] == OP_LDR))
			ld_open = 1'b1;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	endtask

	// Start address write; only called with nothing in flight.
	task automatic write_start(input word_t addr);
		@(negedge clk);
		cfg_data <= addr;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and let every expected beat come home.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		word_t phase_start;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = 1'b0;
		instruction_word = '0;
		read_data = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		ld_open = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Start just below the top so the PC wraps inside the directed part.
		write_start(32'hFFFF_FFF8);

		issue(1'b1, '0, 32'hDEAD_BEEF);                    // data with no load open
		issue(1'b0, enc_c2(OP_LA, 5'd1, 5'd0, 17'h0FFFF), '0);   // largest positive c2
		issue(1'b0, enc_c2(OP_LA, 5'd2, 5'd0, 17'h10000), '0);   // most negative c2
		issue(1'b0, enc_c2(OP_ADDI, 5'd3, 5'd2, 17'h1FFFF), '0);
		issue(1'b0, enc_c2(OP_LD, 5'd4, 5'd1, 17'h00010), '0);   // base + displacement
		issue(1'b0, enc_rrr(OP_NOP, 5'd0, 5'd0, 5'd0, 12'h0), '0); // instr while load open
		issue(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(1'b0, enc_c1(OP_LDR, 5'd5, 22'h200000), '0);      // most negative c1
		issue(1'b1, '0, 32'h8000_0000);
		issue(1'b0, enc_c2(OP_ST, 5'd4, 5'd0, 17'h1FFFF), '0);   // absolute store
		issue(1'b0, enc_c1(OP_STR, 5'd5, 22'h1FFFFF), '0);      // largest positive c1
		issue(1'b0, enc_c1(OP_LAR, 5'd6, 22'h000000), '0);
		issue(1'b0, enc_rrr(OP_SHRA, 5'd7, 5'd5, 5'd1, 12'h000), '0); // amount from R1
		issue(1'b0, enc_rrr(OP_SHR, 5'd8, 5'd5, 5'd0, 12'h01F), '0);
		issue(1'b0, enc_rrr(OP_SHL, 5'd9, 5'd4, 5'd0, 12'h001), '0);
		issue(1'b0, enc_rrr(OP_NEG, 5'd10, 5'd0, 5'd5, 12'h000), '0);
		issue(1'b0, enc_rrr(OP_SUB, 5'd11, 5'd0, 5'd4, 12'h000), '0);
		issue(1'b0, enc_rrr(OP_ADD, 5'd12, 5'd4, 5'd4, 12'h000), '0);
		issue(1'b0, enc_rrr(OP_NOT, 5'd13, 5'd0, 5'd0, 12'h000), '0);
		issue(1'b0, enc_rrr(OP_BR, 5'd0, 5'd1, 5'd0, {9'd0, CND_ZERO}), '0);
		// link register is also the branch target: target must be the old value
		issue(1'b0, enc_rrr(OP_BRL, 5'd1, 5'd1, 5'd5, {9'd0, CND_MINUS}), '0);
		issue(1'b0, enc_rrr(OP_BR, 5'd0, 5'd4, 5'd0, {9'd0, CND_NEVER}), '0);
		issue(1'b0, enc_rrr(OP_BAD7, 5'd3, 5'd3, 5'd3, 12'hFFF), '0);
		issue(1'b0, enc_rrr(OP_BAD25, 5'd3, 5'd3, 5'd3, 12'hFFF), '0);
		issue(1'b0, enc_rrr(OP_STOP, 5'd0, 5'd0, 5'd0, 12'h000), '0);
		issue(1'b0, enc_rrr(OP_SHC, 5'd2, 5'd2, 5'd2, 12'h003), '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: phase_start = 32'h0000_0000;
				1: phase_start = 32'hFFFF_FFFF;
				2: phase_start = 32'h8000_0000;
				3: phase_start = $urandom();
				default: phase_start = 32'h0000_1000;
			endcase
			write_start(phase_start);
			// phase 2 runs flat out mid-run; the last phase has no idling
			tx_idle_en = (ph != 2) && (ph != PHASES - 1);
			rx_idle_en = (ph != 2) && (ph != PHASES - 1);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (ld_open) begin
					// mostly complete the load, sometimes break the sequence
					if ($urandom_range(0, 9) != 0)
						issue(1'b1, $urandom(), rand_data());
					else
						issue(1'b0, rand_instr(), $urandom());
				end else if ($urandom_range(0, 24) == 0) begin
					issue(1'b1, $urandom(), $urandom());
				end else begin
					issue(1'b0, rand_instr(), $urandom());
				end
			end
		end

		drain();
		// a stray late beat would show up here
		repeat (8) @(negedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> src_risc_instruction_execute.f
rtl/srcie_pkg.sv
rtl/src_risc_instruction_execute.sv
tb/srcie_exec_checker.sv
tb/tb_top.sv
